// ===== rtl/core/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Slot record layout, status and operation codes, and the key ordering.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int CAPACITY  = 16;
   localparam int ID_BITS   = 8;
   localparam int TIME_BITS = 32;

   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] sequence_num;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   // true when key a sorts strictly before key b
   function automatic logic key_before(input slot_type a, input slot_type b);
      logic result;
      if (a.deadline != b.deadline) begin
         result = (a.deadline < b.deadline);
      end else begin
         result = (a.sequence_num < b.sequence_num);
      end
      return result;
   endfunction

endpackage

// ===== rtl/core/stq_ram.sv =====
// ----------------------------------------------------------------------------
// stq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sorted_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit: sorted timer table with insert and delete by id
// Flow: an insert shifts slots up from the tail to its place, a delete scans
//   for the id and shifts later slots down; then the head slot is read.
// Handshake: one item at a time; the next item is accepted the cycle after
//   the result is taken.
// Reset: synchronous, clears the entry count and control state; slot RAM is
//   left as is and only the contents of occupied slots are ever used.
// ----------------------------------------------------------------------------
module sorted_timer_queue_unit
   import stq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [ID_BITS-1:0]   req_timer_id,
   input  logic [TIME_BITS-1:0] req_deadline,
   input  logic [TIME_BITS-1:0] req_sequence_req,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [CNT_BITS-1:0]  rsp_entry_count,
   output logic                 rsp_min_valid,
   output logic [ID_BITS-1:0]   rsp_min_id,
   output logic [TIME_BITS-1:0] rsp_min_deadline,
   output logic [TIME_BITS-1:0] rsp_min_sequence
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_DEL_RD,
      S_DEL_CMP,
      S_SH_RD,
      S_SH_CMP,
      S_FIN,
      S_LOAD,
      S_RESP
   } state_type;

   state_type            state_ff,  state_in;
   logic [CNT_BITS-1:0]  idx_ff,    idx_in;
   logic [CNT_BITS-1:0]  count_ff,  count_in;
   slot_type             item_ff,   item_in;
   logic [1:0]           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   slot_type             min_ff,    min_in;
   logic                 min_valid_ff, min_valid_in;

   logic                 ram_we;
   logic [IDX_BITS-1:0]  ram_waddr;
   slot_type             ram_wdata;
   logic [IDX_BITS-1:0]  ram_raddr;
   logic [SLOT_BITS-1:0] ram_rdata;
   slot_type             rd_slot;
   logic [CNT_BITS-1:0]  idx_dec;
   logic [CNT_BITS-1:0]  idx_inc;

   assign rd_slot = slot_type'(ram_rdata);
   assign idx_dec = idx_ff - CNT_BITS'(1);
   assign idx_inc = idx_ff + CNT_BITS'(1);

   stq_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (SLOT_BITS'(ram_wdata)),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      item_in      = item_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      min_in       = min_ff;
      min_valid_in = min_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[IDX_BITS-1:0];
      ram_wdata    = item_ff;
      ram_raddr    = idx_ff[IDX_BITS-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in.id           = req_timer_id;
               item_in.deadline     = req_deadline;
               item_in.sequence_num = req_sequence_req;
               status_in            = STATUS_OK;
               if (req_operation == OP_INSERT) begin
                  if (count_ff >= CNT_BITS'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_FIN;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_INS_RD;
                  end
               end else begin
                  idx_in   = '0;
                  state_in = S_DEL_RD;
               end
            end
         end
         S_INS_RD: begin
            ram_raddr = idx_dec[IDX_BITS-1:0];
            if (idx_ff == '0) begin
               ram_we   = 1'b1;
               count_in = count_ff + CNT_BITS'(1);
               state_in = S_FIN;
            end else begin
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            ram_we = 1'b1;
            if (key_before(item_ff, rd_slot)) begin
               ram_wdata = rd_slot;
               idx_in    = idx_dec;
               state_in  = S_INS_RD;
            end else begin
               count_in = count_ff + CNT_BITS'(1);
               state_in = S_FIN;
            end
         end
         S_DEL_RD: begin
            if (idx_ff == count_ff) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = S_FIN;
            end else begin
               state_in = S_DEL_CMP;
            end
         end
         S_DEL_CMP: begin
            if (rd_slot.id == item_ff.id) begin
               state_in = S_SH_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_DEL_RD;
            end
         end
         S_SH_RD: begin
            ram_raddr = idx_inc[IDX_BITS-1:0];
            if (idx_inc == count_ff) begin
               count_in = count_ff - CNT_BITS'(1);
               state_in = S_FIN;
            end else begin
               state_in = S_SH_CMP;
            end
         end
         S_SH_CMP: begin
            ram_we    = 1'b1;
            ram_wdata = rd_slot;
            idx_in    = idx_inc;
            state_in  = S_SH_RD;
         end
         S_FIN: begin
            ram_raddr = '0;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            min_valid_in = (count_ff != '0);
            min_in       = (count_ff != '0) ? rd_slot : '0;
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      item_ff      <= item_in;
      status_ff    <= status_in;
      min_ff       <= min_in;
      min_valid_ff <= min_valid_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_min_valid    = min_valid_ff;
   assign rsp_min_id       = min_ff.id;
   assign rsp_min_deadline = min_ff.deadline;
   assign rsp_min_sequence = min_ff.sequence_num;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the sorted timer queue unit
// Each insert or delete is predicted against a shadow copy of the sorted
// timer table. Every result is checked field by field, in order. A short
// stimulus table covers the edge cases first: empty and full table, equal
// keys, duplicate ids and extreme values. Random fill and drain phases
// follow. Both sides idle at random, with two long result hold-offs and
// pauses until all results are in.
// ----------------------------------------------------------------------------
module tb
   import stq_pkg::*;
();

   localparam int RANDOM_ITEMS   = 1926;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [1:0]           status;
      logic [CNT_BITS-1:0]  count;
      logic                 min_valid;
      logic [ID_BITS-1:0]   min_id;
      logic [TIME_BITS-1:0] min_deadline;
      logic [TIME_BITS-1:0] min_seq;
   } head_report_type;

   typedef struct packed {
      logic                 op;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] seq;
      logic                 known;
      head_report_type      want;
   } timer_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_operation;
   logic [ID_BITS-1:0]   req_timer_id;
   logic [TIME_BITS-1:0] req_deadline;
   logic [TIME_BITS-1:0] req_sequence_req;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_status;
   logic [CNT_BITS-1:0]  rsp_entry_count;
   logic                 rsp_min_valid;
   logic [ID_BITS-1:0]   rsp_min_id;
   logic [TIME_BITS-1:0] rsp_min_deadline;
   logic [TIME_BITS-1:0] rsp_min_sequence;

   slot_type        shadow_slot [CAPACITY];
   int              shadow_count;
   head_report_type head_reports [$];
   timer_row_type   timer_plan [$];
   int              mismatches;
   int              idle_cycles;
   bit              quiet;
   int              hold_asks;

   sorted_timer_queue_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_timer_id     (req_timer_id),
      .req_deadline     (req_deadline),
      .req_sequence_req (req_sequence_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_min_valid    (rsp_min_valid),
      .rsp_min_id       (rsp_min_id),
      .rsp_min_deadline (rsp_min_deadline),
      .rsp_min_sequence (rsp_min_sequence)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic timer_row_type timer_op(input logic op, input logic [ID_BITS-1:0] id,
                                              input logic [TIME_BITS-1:0] dl,
                                              input logic [TIME_BITS-1:0] sq);
      timer_row_type r;
      r = '0;
      r.op = op;
      r.id = id;
      r.deadline = dl;
      r.seq = sq;
      return r;
   endfunction

   function automatic timer_row_type timer_op_known(input logic op,
                                                    input logic [ID_BITS-1:0] id,
                                                    input logic [TIME_BITS-1:0] dl,
                                                    input logic [TIME_BITS-1:0] sq,
                                                    input logic [1:0] st,
                                                    input int cnt, input logic mv,
                                                    input logic [ID_BITS-1:0] mid,
                                                    input logic [TIME_BITS-1:0] mdl,
                                                    input logic [TIME_BITS-1:0] msq);
      timer_row_type r;
      r = timer_op(op, id, dl, sq);
      r.known = 1'b1;
      r.want.status = st;
      r.want.count = cnt[CNT_BITS-1:0];
      r.want.min_valid = mv;
      r.want.min_id = mid;
      r.want.min_deadline = mdl;
      r.want.min_seq = msq;
      return r;
   endfunction

   // strict ordering: deadline first, then sequence number
   function automatic bit sorts_ahead(input logic [TIME_BITS-1:0] dl,
                                      input logic [TIME_BITS-1:0] sq, input slot_type s);
      if (dl != s.deadline) begin
         return dl < s.deadline;
      end
      return sq < s.sequence_num;
   endfunction

   task automatic track_timer_op(input timer_row_type r, output head_report_type rep);
      int pos;
      int k;
      rep = '0;
      rep.status = STATUS_OK;
      if (r.op == OP_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            rep.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_count && !sorts_ahead(r.deadline, r.seq, shadow_slot[pos]))
               pos++;
            for (k = shadow_count; k > pos; k--)
               shadow_slot[k] = shadow_slot[k-1];
            shadow_slot[pos].id = r.id;
            shadow_slot[pos].deadline = r.deadline;
            shadow_slot[pos].sequence_num = r.seq;
            shadow_count++;
         end
      end else begin
         pos = 0;
         while (pos < shadow_count && shadow_slot[pos].id != r.id)
            pos++;
         if (pos >= shadow_count) begin
            rep.status = STATUS_NOT_FOUND;
         end else begin
            for (k = pos; k + 1 < shadow_count; k++)
               shadow_slot[k] = shadow_slot[k+1];
            shadow_count--;
         end
      end
      rep.count = shadow_count[CNT_BITS-1:0];
      if (shadow_count > 0) begin
         rep.min_valid = 1'b1;
         rep.min_id = shadow_slot[0].id;
         rep.min_deadline = shadow_slot[0].deadline;
         rep.min_seq = shadow_slot[0].sequence_num;
      end
   endtask

   task automatic offer_request(input timer_row_type r);
      int gap;
      head_report_type rep;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation = r.op;
      req_timer_id = r.id;
      req_deadline = r.deadline;
      req_sequence_req = r.seq;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      track_timer_op(r, rep);
      head_reports.push_back(r.known ? r.want : rep);
      @(negedge clock);
   endtask

   function automatic logic [TIME_BITS-1:0] draw_time(input logic [TIME_BITS-1:0] near);
      case ($urandom_range(0, 7))
         0: return TIME_BITS'($urandom_range(0, 3));
         1: return TIME_MAX - TIME_BITS'($urandom_range(0, 3));
         2: return near;
         default: return TIME_BITS'($urandom);
      endcase
   endfunction

   task automatic check_report(input head_report_type want, input head_report_type got);
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
         mismatches++;
      end
      if (got.count !== want.count) begin
         $display("%0t: entry_count expected %0d got %0d", $time, want.count, got.count);
         mismatches++;
      end
      if (got.min_valid !== want.min_valid) begin
         $display("%0t: min_valid expected %0d got %0d", $time, want.min_valid,
                  got.min_valid);
         mismatches++;
      end
      if (got.min_id !== want.min_id) begin
         $display("%0t: min_id expected %0h got %0h", $time, want.min_id, got.min_id);
         mismatches++;
      end
      if (got.min_deadline !== want.min_deadline) begin
         $display("%0t: min_deadline expected %0h got %0h", $time, want.min_deadline,
                  got.min_deadline);
         mismatches++;
      end
      if (got.min_seq !== want.min_seq) begin
         $display("%0t: min_sequence expected %0h got %0h", $time, want.min_seq,
                  got.min_seq);
         mismatches++;
      end
   endtask

   // result side
   initial begin
      int stall;
      int holds_done;
      head_report_type got;
      rsp_ready = 1'b0;
      holds_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_asks > holds_done) begin
            stall = LONG_HOLD;
            holds_done++;
         end else begin
            stall = quiet ? 0 : $urandom_range(0, 3);
         end
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.status = rsp_status;
         got.count = rsp_entry_count;
         got.min_valid = rsp_min_valid;
         got.min_id = rsp_min_id;
         got.min_deadline = rsp_min_deadline;
         got.min_seq = rsp_min_sequence;
         if (head_reports.size() == 0) begin
            $display("%0t: unexpected result, status %0d count %0d", $time, got.status,
                     got.count);
            mismatches++;
         end else begin
            check_report(head_reports.pop_front(), got);
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  head_reports.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // request side
   initial begin
      int n;
      int k;
      bit fill;
      timer_row_type r;
      logic [TIME_BITS-1:0] near_dl;
      logic [TIME_BITS-1:0] near_sq;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_INSERT;
      req_timer_id = '0;
      req_deadline = '0;
      req_sequence_req = '0;
      shadow_count = 0;
      quiet = 1'b0;
      hold_asks = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      timer_plan.push_back(timer_op_known(OP_DELETE, 8'h05, '0, '0,
                                          STATUS_NOT_FOUND, 0, 1'b0, '0, '0, '0));
      timer_plan.push_back(timer_op_known(OP_INSERT, 8'hFF, TIME_MAX, TIME_MAX,
                                          STATUS_OK, 1, 1'b1, 8'hFF, TIME_MAX, TIME_MAX));
      timer_plan.push_back(timer_op_known(OP_INSERT, 8'h00, '0, '0,
                                          STATUS_OK, 2, 1'b1, 8'h00, '0, '0));
      // equal key goes behind the pending one
      timer_plan.push_back(timer_op_known(OP_INSERT, 8'h01, '0, '0,
                                          STATUS_OK, 3, 1'b1, 8'h00, '0, '0));
      timer_plan.push_back(timer_op(OP_INSERT, 8'h02, '0, TIME_MAX));
      timer_plan.push_back(timer_op(OP_DELETE, 8'h00, TIME_MAX, TIME_MAX));
      // duplicate id, delete takes the first one
      timer_plan.push_back(timer_op(OP_INSERT, 8'h01, 32'd5, '0));
      timer_plan.push_back(timer_op(OP_DELETE, 8'h01, '0, '0));
      for (k = 0; k < 13; k++) begin
         if (k == 5) begin
            timer_plan.push_back(timer_op(OP_INSERT, ID_BITS'(16 + k), '0, TIME_MAX));
         end else begin
            timer_plan.push_back(timer_op(OP_INSERT, ID_BITS'(16 + k),
                                          TIME_BITS'(32'h1000 + k), TIME_BITS'(k)));
         end
      end
      timer_plan.push_back(timer_op_known(OP_INSERT, 8'h55, '0, '0,
                                          STATUS_FULL, 16, 1'b1, 8'h02, '0, TIME_MAX));
      timer_plan.push_back(timer_op_known(OP_DELETE, 8'h77, '0, '0,
                                          STATUS_NOT_FOUND, 16, 1'b1, 8'h02, '0, TIME_MAX));
      timer_plan.push_back(timer_op(OP_DELETE, 8'h02, '0, '0));
      foreach (timer_plan[i])
         offer_request(timer_plan[i]);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 400 == 399) begin
            req_valid = 1'b0;
            while (head_reports.size() != 0) @(negedge clock);
         end
         if (n == 600 || n == 1500)
            hold_asks++;
         quiet = (n >= 1200 && n < 1350);
         fill = ((n / 48) % 2 == 0);
         near_dl = '0;
         near_sq = '0;
         if (shadow_count > 0) begin
            k = $urandom_range(0, shadow_count - 1);
            near_dl = shadow_slot[k].deadline;
            near_sq = shadow_slot[k].sequence_num;
         end
         r = timer_op(OP_INSERT, ID_BITS'($urandom_range(0, 255)), draw_time(near_dl),
                      draw_time(near_sq));
         if ($urandom_range(0, 99) >= (fill ? 80 : 30)) begin
            r.op = OP_DELETE;
            if (shadow_count > 0 && $urandom_range(0, 3) != 0)
               r.id = shadow_slot[$urandom_range(0, shadow_count - 1)].id;
         end else if (shadow_count > 0 && $urandom_range(0, 7) == 0) begin
            r.id = shadow_slot[$urandom_range(0, shadow_count - 1)].id;
         end
         offer_request(r);
      end

      req_valid = 1'b0;
      while (head_reports.size() != 0) @(negedge clock);
      repeat (2 * CAPACITY + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
